// File: rtl/cmws_pkg.sv
// Shared types and constants for the circular minimum window sum core.
// No dependencies.
package cmws_pkg;
  localparam int MAX_ITEMS_DEF = 1024;
  localparam int TGT_W = 63;
  localparam int VAL_W = 32;
  localparam int IDX_W = 11;
  localparam logic [62:0] SAT63 = {63{1'b1}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_DIV, ST_MUL, ST_SCAN_RD, ST_SCAN_ADD, ST_SCAN_CHK, ST_SCAN_SUB,
    ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // store beat, add to total
    logic clear;      // reset count and total
    logic div_start;
    logic mul_start;
    logic scan_init;
    logic add_hi;     // sum += rdata
    logic rd_lo;      // issue read at lo
    logic check;      // compare and record best
    logic sub_lo;     // sum -= rdata, lo++
    logic adv_hi;     // hi++
    logic finish;     // compute count
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic rem_zero;
    logic total_zero;
    logic sum_ge;     // sum >= need and lo <= hi
    logic hi_end;     // hi == 2n - 1
  } sts_t;
endpackage

// File: rtl/circular_min_window_sum_core.sv
// channel   | dir | payload
// s_axis    | in  | tdata[31:0] item_value, tlast is_last
// m_axis    | out | tdata[10:0] start_index, tdata[73:11] element_count
// cfg       | in  | cfg_we, cfg_data target_sum
// Loading accepts one beat per cycle. After the last beat: restoring divide,
// serial multiply, then a scan over 2n positions, where a hi step reads, adds
// and checks and a lo step checks and subtracts (single RAM read port), then a
// finish step. No beat is taken from the last beat until the result is
// consumed. rst is synchronous, clears counts and returns the target to 1.
// Top level of the circular minimum window sum core. Depends on cmws_pkg,
// cmws_ctrl and cmws_dp.
module circular_min_window_sum_core #(
  parameter int MAX_ITEMS = cmws_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [10:0] start_index, [73:11] element_count
  input  logic        cfg_we,
  input  logic [62:0] cfg_data
);
  cmws_pkg::cmd_t cmd;
  cmws_pkg::sts_t sts;
  logic [cmws_pkg::IDX_W-1:0] start_index;
  logic [cmws_pkg::TGT_W-1:0] element_count;

  cmws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (s_axis_tvalid && s_axis_tready),
    .in_last   (s_axis_tlast),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  cmws_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item_value    (s_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .sts           (sts),
    .start_index   (start_index),
    .element_count (element_count)
  );

  assign m_axis_tdata = {6'd0, element_count, start_index};
endmodule

// File: rtl/cmws_ram.sv
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module cmws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/cmws_ctrl.sv
// Controller state machine for the circular minimum window sum core.
// Depends on cmws_pkg.
module cmws_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_beat,
  input  logic            in_last,
  input  logic            out_ready,
  input  cmws_pkg::sts_t  sts,
  output cmws_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            out_valid
);
  cmws_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmws_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      cmws_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_beat) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.div_start = 1'b1;
            state_next = cmws_pkg::ST_DIV;
          end
        end
      end
      cmws_pkg::ST_DIV: begin
        if (sts.total_zero) begin
          state_next = cmws_pkg::ST_FIN;
        end else if (sts.div_done) begin
          cmd.mul_start = 1'b1;
          state_next = cmws_pkg::ST_MUL;
        end
      end
      cmws_pkg::ST_MUL: begin
        if (sts.mul_done) begin
          if (sts.rem_zero) begin
            state_next = cmws_pkg::ST_FIN;
          end else begin
            cmd.scan_init = 1'b1;
            state_next = cmws_pkg::ST_SCAN_RD;
          end
        end
      end
      cmws_pkg::ST_SCAN_RD: begin
        state_next = cmws_pkg::ST_SCAN_ADD;
      end
      cmws_pkg::ST_SCAN_ADD: begin
        cmd.add_hi = 1'b1;
        cmd.rd_lo = 1'b1;
        state_next = cmws_pkg::ST_SCAN_CHK;
      end
      cmws_pkg::ST_SCAN_CHK: begin
        if (sts.sum_ge) begin
          cmd.check = 1'b1;
          cmd.rd_lo = 1'b1;
          state_next = cmws_pkg::ST_SCAN_SUB;
        end else if (sts.hi_end) begin
          state_next = cmws_pkg::ST_FIN;
        end else begin
          cmd.adv_hi = 1'b1;
          state_next = cmws_pkg::ST_SCAN_RD;
        end
      end
      cmws_pkg::ST_SCAN_SUB: begin
        cmd.sub_lo = 1'b1;
        cmd.rd_lo = 1'b1;
        state_next = cmws_pkg::ST_SCAN_CHK;
      end
      cmws_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = cmws_pkg::ST_OUT;
      end
      cmws_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = cmws_pkg::ST_LOAD;
        end
      end
      default: state_next = cmws_pkg::ST_LOAD;
    endcase
  end
endmodule

// File: rtl/cmws_dp.sv
// Datapath: value store, running total, restoring divider, serial multiplier,
// two-pointer window scan. Depends on cmws_pkg and cmws_ram.
module cmws_dp #(
  parameter int MAX_ITEMS = cmws_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cmws_pkg::cmd_t                    cmd,
  input  logic [cmws_pkg::VAL_W-1:0]        item_value,
  input  logic                              cfg_we,
  input  logic [cmws_pkg::TGT_W-1:0]        cfg_data,
  output cmws_pkg::sts_t                    sts,
  output logic [cmws_pkg::IDX_W-1:0]        start_index,
  output logic [cmws_pkg::TGT_W-1:0]        element_count
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 1;                    // pointers up to 2n
  localparam int TW = cmws_pkg::VAL_W + CW;      // total width
  localparam int TGW = cmws_pkg::TGT_W;
  localparam int DCW = $clog2(TGW + 1);
  localparam int MCW = $clog2(CW + 1);

  logic [TGW-1:0] target;
  logic [CW-1:0]  count;
  logic [TW-1:0]  total;

  // divider
  logic [TGW-1:0] quo;
  logic [TW:0]    rem;
  logic [DCW-1:0] dcnt;
  logic           dbusy;
  logic           div_fin;
  logic [TW:0]    rem_sh;
  logic [TW:0]    rem_dif;

  // multiplier (shift-add over count bits)
  logic [TGW:0]   prod;
  logic [CW-1:0]  mcand;
  logic [TGW-1:0] mplier;
  logic           movf;
  logic           ovf;
  logic [MCW-1:0] mcnt;
  logic           mbusy;

  // scan
  logic [PW-1:0]  hi, lo;
  logic [TW-1:0]  sum;
  logic [PW-1:0]  blen;
  logic [CW-1:0]  bstart;
  logic [AW-1:0]  raddr, waddr;
  logic [cmws_pkg::VAL_W-1:0] rdata;
  logic [PW-1:0]  lo_mod, hi_mod, len;
  logic [CW-1:0]  s_cur;
  logic [PW-1:0]  n2;

  assign waddr = count[AW-1:0];

  cmws_ram #(.WIDTH(cmws_pkg::VAL_W), .DEPTH(MAX_ITEMS)) u_ram (
    .clk   (clk),
    .we    (cmd.load && (count < CW'(MAX_ITEMS))),
    .waddr (waddr),
    .wdata (item_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n2 = {count, 1'b0};
  assign hi_mod = (hi >= PW'(count)) ? hi - PW'(count) : hi;
  assign lo_mod = (lo >= PW'(count)) ? lo - PW'(count) : lo;
  assign len = hi - lo + PW'(1);
  assign s_cur = lo_mod[CW-1:0];

  always_comb begin
    raddr = hi_mod[AW-1:0];
    if (cmd.rd_lo) begin
      raddr = lo_mod[AW-1:0];
    end
  end

  assign rem_sh = {rem[TW-1:0], quo[TGW-1]};
  assign rem_dif = rem_sh - {1'b0, total};

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TGW'(1);
      count <= '0;
      total <= '0;
      dbusy <= 1'b0;
      div_fin <= 1'b0;
      mbusy <= 1'b0;
    end else begin
      if (cfg_we) begin
        target <= cfg_data;
      end
      if (cmd.clear) begin
        count <= '0;
        total <= '0;
      end else if (cmd.load && (count < CW'(MAX_ITEMS))) begin
        count <= count + CW'(1);
        total <= total + TW'(item_value);
      end
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        div_fin <= 1'b0;
      end else if (dbusy && dcnt == DCW'(TGW - 1)) begin
        dbusy <= 1'b0;
        div_fin <= 1'b1;
      end
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
      end else if (mbusy && mcnt == MCW'(CW - 1)) begin
        mbusy <= 1'b0;
      end
    end
  end

  // restoring divide, one quotient bit per cycle; quo shifts in from target
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= target;
      rem <= '0;
      dcnt <= '0;
    end else if (dbusy) begin
      dcnt <= dcnt + DCW'(1);
      if (!rem_dif[TW]) begin
        rem <= rem_dif;
        quo <= {quo[TGW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[TGW-2:0], 1'b0};
      end
    end
  end

  // quo * count, MSB first over count bits, saturate on overflow
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod <= '0;
      movf <= 1'b0;
      mcand <= count;
      mplier <= quo;
      mcnt <= '0;
    end else if (mbusy) begin
      mcnt <= mcnt + MCW'(1);
      mcand <= {mcand[CW-2:0], 1'b0};
      if (prod[TGW-1] || prod[TGW]) begin
        movf <= 1'b1;
      end
      if (mcand[CW-1]) begin
        prod <= {prod[TGW-1:0], 1'b0} + {1'b0, mplier};
      end else begin
        prod <= {prod[TGW-1:0], 1'b0};
      end
    end else if (prod[TGW]) begin
      movf <= 1'b1;
    end
  end

  assign ovf = movf || prod[TGW];

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      hi <= '0;
      lo <= '0;
      sum <= '0;
      blen <= PW'(count) + PW'(1);
      bstart <= '0;
    end else begin
      if (cmd.add_hi) begin
        sum <= sum + TW'(rdata);
      end
      if (cmd.check) begin
        if (len < blen || (len == blen && s_cur < bstart)) begin
          blen <= len;
          bstart <= s_cur;
        end
      end
      if (cmd.sub_lo) begin
        sum <= sum - TW'(rdata);
        lo <= lo + PW'(1);
      end
      if (cmd.adv_hi) begin
        hi <= hi + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (total == '0) begin
        start_index <= cmws_pkg::IDX_W'(1);
        element_count <= cmws_pkg::SAT63;
      end else if (ovf) begin
        start_index <= (rem == '0) ? cmws_pkg::IDX_W'(1)
                       : cmws_pkg::IDX_W'(bstart) + cmws_pkg::IDX_W'(1);
        element_count <= cmws_pkg::SAT63;
      end else if (rem == '0) begin
        start_index <= cmws_pkg::IDX_W'(1);
        element_count <= prod[TGW-1:0];
      end else begin
        start_index <= cmws_pkg::IDX_W'(bstart) + cmws_pkg::IDX_W'(1);
        if ({1'b0, prod[TGW-1:0]} + (TGW+1)'(blen) > {1'b0, cmws_pkg::SAT63}) begin
          element_count <= cmws_pkg::SAT63;
        end else begin
          element_count <= prod[TGW-1:0] + TGW'(blen);
        end
      end
    end
  end

  assign sts.div_done = div_fin;
  assign sts.mul_done = mbusy && mcnt == MCW'(CW - 1);
  assign sts.rem_zero = (rem == '0);
  assign sts.total_zero = (total == '0);
  assign sts.sum_ge = (TW'(sum) >= rem[TW-1:0]) && (lo <= hi);
  assign sts.hi_end = (hi == n2 - PW'(1));
endmodule
